// ===== sv/ght_pkg.sv =====
// Shared types and constants for the generational handle table.
// Used by generational_handle_table_unit; no dependencies.
package ght_pkg;

   localparam int SLOTS_DEF    = 32;
   localparam int OBJ_BITS_DEF = 16;

   localparam int ID_W     = 32;
   localparam int GEN_W    = 16;
   localparam int OBJ_W    = 16;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 6;

   typedef enum logic [2:0] {
      OP_ALLOC    = 3'd0,
      OP_REGISTER = 3'd1,
      OP_LOOKUP   = 3'd2,
      OP_RELEASE  = 3'd3,
      OP_CLEAR    = 3'd4,
      OP_LIST     = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_BAD_ID    = 3'd2,
      ST_OCCUPIED  = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LIST_RD,
      S_LIST_OUT
   } fsm_type;

endpackage

// ===== sv/generational_handle_table_unit.sv =====
// Generational handle table: allocate, register, lookup, release, clear, list.
// Ordinary request: the entry memory is read synchronously on acceptance, then the
// decide/write-back state fills the result register once free; requests stall until idle.
// List: each occupied slot is read (S_LIST_RD), then sent (S_LIST_OUT); one read per entry.
// Synchronous active-high reset empties the table (valid flops), zeroes the count and
// sets the generation to one; entry contents stay undefined until written, no clearing pass.
module generational_handle_table_unit #(
   parameter int SLOTS       = ght_pkg::SLOTS_DEF,
   parameter int OBJECT_BITS = ght_pkg::OBJ_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [2:0]                    req_type,
   input  logic [ght_pkg::ID_W-1:0]      req_handle_id,
   input  logic [ght_pkg::OBJ_W-1:0]     req_object_ref,
   input  logic                          req_safe_check,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ght_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ght_pkg::ID_W-1:0]      rsp_result_id,
   output logic [ght_pkg::OBJ_W-1:0]     rsp_result_object,
   output logic                          rsp_found,
   output logic [ght_pkg::OCC_W-1:0]     rsp_occupancy,
   output logic                          rsp_last
);
   import ght_pkg::*;

   localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CntW  = $clog2(SLOTS + 1);
   localparam int ObjW  = (OBJECT_BITS < OBJ_W) ? OBJECT_BITS : OBJ_W;
   localparam int MemW  = ID_W + ObjW;

   // entry memory: {identifier, object}
   logic [MemW-1:0]      slot_mem_ff [SLOTS];
   logic [MemW-1:0]      mem_rd_ff;
   logic                 mem_we, mem_re;
   logic [IdxW-1:0]      mem_waddr, mem_raddr;
   logic [MemW-1:0]      mem_wdata;

   fsm_type              state_ff, state_in;
   logic [SLOTS-1:0]     valid_ff, valid_in;
   logic [GEN_W-1:0]     gen_ff, gen_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [IdxW-1:0]      cur_ff, cur_in;
   logic                 lst_last_ff, lst_last_in;

   logic [2:0]           op_ff;
   logic [ID_W-1:0]      id_ff;
   logic [ObjW-1:0]      obj_ff;
   logic                 safe_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [ObjW-1:0]      rsp_obj_ff, rsp_obj_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [CntW-1:0]      rsp_occ_ff, rsp_occ_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 rsp_free;
   logic                 free_any;
   logic [IdxW-1:0]      free_idx;
   logic [IdxW-1:0]      lst_idx;
   logic                 lst_more;
   logic [IdxW-1:0]      idx;
   logic                 idx_ok;
   logic [ID_W-1:0]      rd_ident;
   logic [ObjW-1:0]      rd_obj;

   function automatic op_type op_ty(input logic [2:0] code);
      return op_type'(code);
   endfunction

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign idx      = id_ff[IdxW-1:0];
   assign idx_ok   = id_ff[15:0] < 16'(SLOTS);
   assign rd_ident = mem_rd_ff[MemW-1:ObjW];
   assign rd_obj   = mem_rd_ff[ObjW-1:0];

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IdxW'(i);
         end
      end
   end

   // next occupied slot at or above the list cursor, and whether another follows it
   always_comb begin
      lst_idx  = '0;
      lst_more = 1'b0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (valid_ff[i] && IdxW'(i) >= cur_ff) begin
            lst_idx = IdxW'(i);
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (valid_ff[i] && IdxW'(i) > lst_idx) begin
            lst_more = 1'b1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      gen_in        = gen_ff;
      cnt_in        = cnt_ff;
      cur_in        = cur_ff;
      lst_last_in   = lst_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_obj_in    = rsp_obj_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx;
      mem_wdata     = {id_ff, obj_ff};
      mem_re        = 1'b0;
      mem_raddr     = req_handle_id[IdxW-1:0];

      case (state_ff)
         S_IDLE: begin
            // read the named entry while the request is captured
            if (req_valid) begin
               mem_re   = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_ff == OP_LIST && valid_ff != '0) begin
               cur_in   = '0;
               state_in = S_LIST_RD;
            end else if (rsp_free) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_id_in     = '0;
               rsp_obj_in    = '0;
               rsp_found_in  = 1'b0;
               rsp_last_in   = 1'b1;
               case (op_ty(op_ff))
                  OP_ALLOC: begin
                     if (free_any) begin
                        mem_we             = 1'b1;
                        mem_waddr          = free_idx;
                        mem_wdata          = {gen_ff, 16'(free_idx), obj_ff};
                        valid_in[free_idx] = 1'b1;
                        gen_in             = gen_ff + 1'b1;
                        cnt_in             = cnt_ff + 1'b1;
                        rsp_id_in          = {gen_ff, 16'(free_idx)};
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  OP_REGISTER: begin
                     if (id_ff == '0 || !idx_ok) begin
                        rsp_status_in = ST_BAD_ID;
                     end else if (valid_ff[idx]) begin
                        rsp_status_in = ST_OCCUPIED;
                     end else begin
                        mem_we        = 1'b1;
                        valid_in[idx] = 1'b1;
                        cnt_in        = cnt_ff + 1'b1;
                     end
                  end
                  OP_LOOKUP: begin
                     if (id_ff == '0 || !idx_ok) begin
                        rsp_status_in = ST_BAD_ID;
                     end else if (!valid_ff[idx] || (safe_ff && rd_ident != id_ff)) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        rsp_id_in    = rd_ident;
                        rsp_obj_in   = rd_obj;
                        rsp_found_in = 1'b1;
                     end
                  end
                  OP_RELEASE: begin
                     if (!idx_ok) begin
                        rsp_status_in = ST_BAD_ID;
                     end else if (!valid_ff[idx] || rd_obj != obj_ff) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        valid_in[idx] = 1'b0;
                        cnt_in        = cnt_ff - 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     valid_in = '0;
                     cnt_in   = '0;
                  end
                  OP_LIST: begin
                     // empty table: single closing transfer
                  end
                  default: begin
                     rsp_status_in = ST_BAD_ID;
                  end
               endcase
               rsp_occ_in = cnt_in;
            end
         end
         S_LIST_RD: begin
            mem_re      = 1'b1;
            mem_raddr   = lst_idx;
            lst_last_in = !lst_more;
            cur_in      = lst_idx + 1'b1;
            state_in    = S_LIST_OUT;
         end
         S_LIST_OUT: begin
            // read data holds until the result register frees up
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_id_in     = rd_ident;
               rsp_obj_in    = rd_obj;
               rsp_found_in  = 1'b1;
               rsp_occ_in    = cnt_ff;
               rsp_last_in   = lst_last_ff;
               state_in      = lst_last_ff ? S_IDLE : S_LIST_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= slot_mem_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff   <= req_type;
         id_ff   <= req_handle_id;
         obj_ff  <= req_object_ref[ObjW-1:0];
         safe_ff <= req_safe_check;
      end
      cur_ff        <= cur_in;
      lst_last_ff   <= lst_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_obj_ff    <= rsp_obj_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         gen_ff       <= GEN_W'(1);
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         gen_ff       <= gen_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_id     = rsp_id_ff;
   assign rsp_result_object = OBJ_W'(rsp_obj_ff);
   assign rsp_found         = rsp_found_ff;
   assign rsp_occupancy     = OCC_W'(rsp_occ_ff);
   assign rsp_last          = rsp_last_ff;

   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(cnt_ff))
      else $error("occupancy count differs from valid slots");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_EXEC)
      else $error("accepted request not executed next cycle");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == ST_OK)
      else $error("found result with failing status");

   a_list_hit_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LIST_RD |-> valid_ff[lst_idx])
      else $error("list read of an empty slot");

endmodule

// ===== tb/sv/tb_generational_handle_table_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for generational_handle_table_unit: directed and random
// traffic checked against an in-bench scoreboard. Depends on ght_pkg.
module tb_generational_handle_table_unit;
   import ght_pkg::*;

   localparam real         CLK_PERIOD  = 2.0;
   localparam int          TBL_SLOTS   = SLOTS_DEF;
   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam int          DRAIN_WAIT  = 100;
   localparam int          HOLD_CYCLES = 300;
   localparam int          IDLE_PCT    = 18;
   localparam int          PRINT_MAX   = 50;
   // request codes the block does not define
   localparam logic [2:0]  OP_RSVD6    = 3'd6;
   localparam logic [2:0]  OP_RSVD7    = 3'd7;

   typedef struct {
      status_type  status;
      logic [31:0] id;
      logic [15:0] obj;
      logic        found;
      logic [5:0]  occ;
      logic        last;
   } handle_rsp_type;

   class handle_scoreboard;
      bit              in_use[TBL_SLOTS];
      logic [31:0]     stored_id[TBL_SLOTS];
      logic [15:0]     stored_obj[TBL_SLOTS];
      logic [15:0]     gen_next;
      int unsigned     occupied;
      handle_rsp_type  rsp_queue[$];
      int unsigned     mismatches;

      function new();
         foreach (in_use[i]) begin
            in_use[i]     = 1'b0;
            stored_id[i]  = '0;
            stored_obj[i] = '0;
         end
         gen_next    = 16'd1;
         occupied    = 0;
         mismatches  = 0;
      endfunction

      function void queue_rsp(status_type st, logic [31:0] id, logic [15:0] obj,
                              logic found, logic last);
         handle_rsp_type r;
         r.status = st;
         r.id     = id;
         r.obj    = obj;
         r.found  = found;
         r.occ    = 6'(occupied);
         r.last   = last;
         rsp_queue.push_back(r);
      endfunction

      function int pick_slot(bit want_used);
         int cand[$];
         foreach (in_use[i])
            if (in_use[i] == want_used) cand.push_back(i);
         if (cand.size() == 0) return -1;
         return cand[$urandom_range(cand.size() - 1)];
      endfunction

      // Update the table image for one accepted request and queue its results.
      function void note_request(logic [2:0] op, logic [31:0] id, logic [15:0] obj,
                                 logic safe);
         int   idx;
         bit   idx_ok;
         bit   placed;
         int   n;
         idx    = int'(id[15:0]);
         idx_ok = idx < TBL_SLOTS;
         placed = 1'b0;
         n      = 0;
         case (op)
            OP_ALLOC: begin
               for (int i = 0; i < TBL_SLOTS && !placed; i++) begin
                  if (!in_use[i]) begin
                     in_use[i]     = 1'b1;
                     stored_id[i]  = {gen_next, 16'(i)};
                     stored_obj[i] = obj;
                     occupied++;
                     gen_next++;
                     placed = 1'b1;
                     queue_rsp(ST_OK, stored_id[i], '0, 1'b0, 1'b1);
                  end
               end
               if (!placed) queue_rsp(ST_FULL, '0, '0, 1'b0, 1'b1);
            end
            OP_REGISTER: begin
               if (id == '0 || !idx_ok) begin
                  queue_rsp(ST_BAD_ID, '0, '0, 1'b0, 1'b1);
               end else if (in_use[idx]) begin
                  queue_rsp(ST_OCCUPIED, '0, '0, 1'b0, 1'b1);
               end else begin
                  in_use[idx]     = 1'b1;
                  stored_id[idx]  = id;
                  stored_obj[idx] = obj;
                  occupied++;
                  queue_rsp(ST_OK, '0, '0, 1'b0, 1'b1);
               end
            end
            OP_LOOKUP: begin
               if (id == '0 || !idx_ok)
                  queue_rsp(ST_BAD_ID, '0, '0, 1'b0, 1'b1);
               else if (!in_use[idx] || (safe && stored_id[idx] != id))
                  queue_rsp(ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
               else
                  queue_rsp(ST_OK, stored_id[idx], stored_obj[idx], 1'b1, 1'b1);
            end
            OP_RELEASE: begin
               // match on the object only, the generation is not compared
               if (!idx_ok) begin
                  queue_rsp(ST_BAD_ID, '0, '0, 1'b0, 1'b1);
               end else if (!in_use[idx] || stored_obj[idx] != obj) begin
                  queue_rsp(ST_NOT_FOUND, '0, '0, 1'b0, 1'b1);
               end else begin
                  in_use[idx] = 1'b0;
                  occupied--;
                  queue_rsp(ST_OK, '0, '0, 1'b0, 1'b1);
               end
            end
            OP_CLEAR: begin
               foreach (in_use[i]) in_use[i] = 1'b0;
               occupied = 0;
               queue_rsp(ST_OK, '0, '0, 1'b0, 1'b1);
            end
            OP_LIST: begin
               foreach (in_use[i]) begin
                  if (in_use[i]) begin
                     queue_rsp(ST_OK, stored_id[i], stored_obj[i], 1'b1, 1'b0);
                     n++;
                  end
               end
               if (n == 0) queue_rsp(ST_OK, '0, '0, 1'b0, 1'b1);
               else rsp_queue[rsp_queue.size() - 1].last = 1'b1;
            end
            default: queue_rsp(ST_BAD_ID, '0, '0, 1'b0, 1'b1);
         endcase
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= PRINT_MAX) $display("%0t: mismatch: %s", $time, msg);
      endtask

      task check_result(logic [2:0] st, logic [31:0] id, logic [15:0] obj,
                        logic found, logic [5:0] occ, logic last);
         handle_rsp_type e;
         if (rsp_queue.size() == 0) begin
            report($sformatf("unexpected result status=%0d id=%h", st, id));
         end else begin
            e = rsp_queue.pop_front();
            if (st !== e.status || id !== e.id || obj !== e.obj || found !== e.found ||
                occ !== e.occ || last !== e.last)
               report($sformatf({"got st=%0d id=%h obj=%h fnd=%b occ=%0d last=%b, ",
                                 "exp st=%0d id=%h obj=%h fnd=%b occ=%0d last=%b"},
                                st, id, obj, found, occ, last,
                                e.status, e.id, e.obj, e.found, e.occ, e.last));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_type = OP_ALLOC;
   logic [31:0] req_handle_id = '0;
   logic [15:0] req_object_ref = '0;
   logic        req_safe_check = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_result_id;
   logic [15:0] rsp_result_object;
   logic        rsp_found;
   logic [5:0]  rsp_occupancy;
   logic        rsp_last;

   handle_scoreboard sb = new();
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   bit          rsp_hold_request = 1'b0;
   int unsigned cycle_count;

   generational_handle_table_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_handle_id     (req_handle_id),
      .req_object_ref    (req_object_ref),
      .req_safe_check    (req_safe_check),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_result_id     (rsp_result_id),
      .rsp_result_object (rsp_result_object),
      .rsp_found         (rsp_found),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_last          (rsp_last)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Offer one request, hold it until the transfer, then log it.
   task automatic send_request(logic [2:0] op, logic [31:0] id, logic [15:0] obj,
                               logic safe);
      if (req_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= op;
      req_handle_id  <= id;
      req_object_ref <= obj;
      req_safe_check <= safe;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, id, obj, safe);
   endtask

   task automatic send_random_item();
      int unsigned sel;
      int          s;
      logic [31:0] id;
      logic [15:0] obj;
      sel = $urandom_range(99);
      obj = 16'($urandom);
      if (sel < 24) begin
         send_request(OP_ALLOC, $urandom, obj, 1'($urandom_range(1)));
      end else if (sel < 38) begin
         s = sb.pick_slot(1'b0);
         if (s < 0 || $urandom_range(9) < 4) s = $urandom_range(TBL_SLOTS - 1);
         id = {16'($urandom), 16'(s)};
         if ($urandom_range(9) == 0) id[15:0] = 16'($urandom);
         send_request(OP_REGISTER, id, obj, 1'($urandom_range(1)));
      end else if (sel < 58) begin
         s = sb.pick_slot(1'b1);
         if (s >= 0 && $urandom_range(9) < 8) begin
            id = sb.stored_id[s];
            if ($urandom_range(3) == 0)
               id[31:16] = id[31:16] + 16'(1 + $urandom_range(65534));
         end else begin
            id = {16'($urandom), 16'($urandom_range(TBL_SLOTS + 3))};
         end
         send_request(OP_LOOKUP, id, obj, 1'($urandom_range(1)));
      end else if (sel < 76) begin
         s = sb.pick_slot(1'b1);
         if (s >= 0 && $urandom_range(9) < 8) begin
            id = {16'($urandom), 16'(s)};
            if ($urandom_range(3) != 0) obj = sb.stored_obj[s];
         end else begin
            id = {16'($urandom), 16'($urandom_range(TBL_SLOTS + 3))};
         end
         send_request(OP_RELEASE, id, obj, 1'($urandom_range(1)));
      end else if (sel < 84) begin
         send_request(OP_LIST, $urandom, obj, 1'($urandom_range(1)));
      end else if (sel < 86) begin
         send_request(OP_CLEAR, $urandom, obj, 1'($urandom_range(1)));
      end else if (sel < 93) begin
         send_request(3'($urandom_range(7)), $urandom, obj, 1'($urandom_range(1)));
      end else begin
         // fill the table and run one allocate past full
         repeat (TBL_SLOTS + 1 - sb.occupied)
            send_request(OP_ALLOC, $urandom, 16'($urandom), 1'b0);
      end
   endtask

   // Result side: check each transfer, stall at random or for a long hold.
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_status, rsp_result_id, rsp_result_object, rsp_found,
                            rsp_occupancy, rsp_last);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= rsp_idle_on && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[generational_handle_table_unit] ERROR");
      $finish;
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, zero and out-of-range ids, occupancy, safe lookup, release
      send_request(OP_LIST, '0, '0, 1'b0);
      send_request(OP_LOOKUP, '0, '0, 1'b1);
      send_request(OP_REGISTER, '0, 16'h1111, 1'b0);
      send_request(OP_ALLOC, '1, 16'hffff, 1'b1);
      send_request(OP_ALLOC, '0, 16'h0000, 1'b0);
      send_request(OP_REGISTER, {16'hffff, 16'(TBL_SLOTS - 1)}, 16'habcd, 1'b0);
      send_request(OP_REGISTER, {16'h0042, 16'(TBL_SLOTS - 1)}, 16'h5555, 1'b0);
      send_request(OP_REGISTER, {16'h0000, 16'(TBL_SLOTS)}, 16'h2222, 1'b0);
      send_request(OP_REGISTER, 32'h1234ffff, 16'h3333, 1'b1);
      send_request(OP_LOOKUP, 32'h00010000, '0, 1'b1);
      send_request(OP_LOOKUP, 32'h00050000, '0, 1'b1);
      send_request(OP_LOOKUP, 32'h00050000, '0, 1'b0);
      send_request(OP_LOOKUP, 32'h00010005, '0, 1'b0);
      send_request(OP_LOOKUP, 32'hffffffff, '1, 1'b1);
      send_request(OP_RELEASE, {16'h0000, 16'(TBL_SLOTS + 8)}, 16'hffff, 1'b0);
      send_request(OP_RELEASE, 32'h00000000, 16'h1234, 1'b0);
      send_request(OP_RELEASE, 32'h00000000, 16'hffff, 1'b0);
      send_request(OP_RELEASE, 32'h00000000, 16'hffff, 1'b0);
      send_request(OP_LIST, '1, '1, 1'b1);
      send_request(OP_RSVD6, 32'h00010000, 16'h0001, 1'b0);
      send_request(OP_RSVD7, '1, '1, 1'b1);
      send_request(OP_CLEAR, '0, '0, 1'b0);
      send_request(OP_LIST, '0, '0, 1'b0);

      repeat (60) send_random_item();

      // back-pressure: receiver holds off while requests keep coming
      rsp_hold_request = 1'b1;
      repeat (30) send_random_item();

      // no idling for a stretch
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (30) send_random_item();
      send_request(OP_LIST, '0, '0, 1'b0);

      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (20) send_random_item();
      req_valid <= 1'b0;

      while (sb.rsp_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("[generational_handle_table_unit] OK");
      end else begin
         $display("[generational_handle_table_unit] ERROR");
      end
      $finish;
   end
endmodule
